/* sv/ack_time_rate_limiter_assert.svh */
// Assertion helpers for the ack time rate limiter checker.
// Both expect clk and rst_n in scope.
`ifndef ACK_TIME_RATE_LIMITER_ASSERT_SVH
`define ACK_TIME_RATE_LIMITER_ASSERT_SVH

// same-cycle implication
`define ATRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/atrl_pkg.sv */
package atrl_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 8;
    localparam int PORT_TW   = 48;
    localparam int FACTOR_W  = 16;
    localparam int WEIGHT_W  = 9;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = 16;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 96;
    localparam int M_USER_W  = 2;

    localparam logic [CFG_AW-1:0] CFG_SLOWDOWN = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT   = 1'b1;

    localparam logic [FACTOR_W-1:0] SLOWDOWN_RESET = 16'd259;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 9'd128;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 9'd256;
    localparam logic [31:0]         AVG_RESET      = 32'd1000000;

    typedef enum logic [OP_W-1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_DROP  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;
        logic do_send;
        logic set_error;
        logic rd_entry;
        logic latch_elapsed;
        logic mul;
        logic upd_ack;
        logic upd_drop;
        logic scan_init;
        logic scan_issue;
        logic mark;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic known;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

/* sv/atrl_ram.sv */
module atrl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/atrl_ctrl.sv */
module atrl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  atrl_pkg::stat_t stat,
    output atrl_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ACK_WAIT,
        S_ACK_MUL,
        S_ACK_UPD,
        S_DROP_UPD,
        S_SCAN,
        S_SCAN_FLUSH,
        S_QUERY_END,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    atrl_pkg::OP_SEND:
                    begin
                        cmd.do_send = 1'b1;
                        state_next  = S_FINISH;
                    end
                    atrl_pkg::OP_ACK:
                    begin
                        if (stat.known)
                        begin
                            cmd.rd_entry = 1'b1;
                            state_next   = S_ACK_WAIT;
                        end
                        else
                        begin
                            cmd.set_error = 1'b1;
                            state_next    = S_FINISH;
                        end
                    end
                    atrl_pkg::OP_DROP:
                    begin
                        if (stat.known)
                        begin
                            cmd.mul    = 1'b1;
                            state_next = S_DROP_UPD;
                        end
                        else
                        begin
                            cmd.set_error = 1'b1;
                            state_next    = S_FINISH;
                        end
                    end
                    atrl_pkg::OP_QUERY:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ACK_WAIT:
            begin
                cmd.latch_elapsed = 1'b1;
                state_next        = S_ACK_MUL;
            end
            S_ACK_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACK_UPD;
            end
            S_ACK_UPD:
            begin
                cmd.upd_ack = 1'b1;
                state_next  = S_FINISH;
            end
            S_DROP_UPD:
            begin
                cmd.upd_drop = 1'b1;
                state_next   = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_FLUSH;
                end
            end
            S_SCAN_FLUSH:
            begin
                state_next = S_QUERY_END;
            end
            S_QUERY_END:
            begin
                cmd.mark   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/atrl_dp.sv */
module atrl_dp #(
    parameter int ID_COUNT  = 256,
    parameter int TIME_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [atrl_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [atrl_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [atrl_pkg::M_DATA_W-1:0] m_tdata,
    output logic [atrl_pkg::M_USER_W-1:0] m_tuser,
    input  logic                          cfg_we,
    input  logic [atrl_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [atrl_pkg::CFG_DW-1:0]   cfg_wdata,
    input  atrl_pkg::cmd_t                cmd,
    output atrl_pkg::stat_t               stat
);

    localparam int IW = $clog2(ID_COUNT);
    localparam int PW = TIME_BITS + atrl_pkg::FACTOR_W;
    localparam int BW = TIME_BITS + atrl_pkg::WEIGHT_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    atrl_pkg::op_t                   op_reg;
    logic [atrl_pkg::ID_W-1:0]       id_reg;
    logic [TIME_BITS-1:0]            now_reg;
    logic [TIME_BITS-1:0]            avg_reg;
    logic [atrl_pkg::FACTOR_W-1:0]   factor_reg;
    logic [atrl_pkg::WEIGHT_W-1:0]   weight_reg;
    logic                            valid_reg [ID_COUNT];
    logic                            used_reg [ID_COUNT];
    logic [TIME_BITS-1:0]            elapsed_reg;
    logic [PW-1:0]                   prod_a_reg;
    logic [BW-1:0]                   prod_b_reg;
    logic [IW-1:0]                   scan_addr_reg;
    logic [IW-1:0]                   cmp_idx_reg;
    logic                            cand_reg;
    logic                            cmp_vld_reg;
    logic [TIME_BITS-1:0]            oldest_reg;
    logic [IW-1:0]                   best_reg;
    logic                            found_reg;
    logic                            error_reg;
    logic [TIME_BITS-1:0]            min_reg;
    logic                            m_tvalid_reg;
    logic [atrl_pkg::PORT_TW-1:0]    m_min_reg;
    logic [atrl_pkg::PORT_TW-1:0]    m_avg_reg;
    logic                            m_found_reg;
    logic                            m_error_reg;

    logic [IW-1:0]                   idx;
    logic                            in_range;
    logic [atrl_pkg::WEIGHT_W-1:0]   w_clamp;
    logic [atrl_pkg::WEIGHT_W-1:0]   w_new;
    logic [atrl_pkg::FACTOR_W-1:0]   mul_b;
    logic [PW:0]                     blend_sum;
    logic [TIME_BITS-1:0]            avg_blend;
    logic [TIME_BITS-1:0]            avg_scaled;
    logic [TIME_BITS:0]              qsum;
    logic [TIME_BITS-1:0]            min_next;
    logic [TIME_BITS-1:0]            ram_rdata;
    logic [IW-1:0]                   ram_raddr;
    logic                            hit;

    assign idx      = IW'(id_reg);
    assign in_range = (32'(id_reg) < 32'(ID_COUNT));

    assign w_clamp = (weight_reg > atrl_pkg::WEIGHT_ONE) ? atrl_pkg::WEIGHT_ONE : weight_reg;
    assign w_new   = atrl_pkg::WEIGHT_ONE - w_clamp;
    assign mul_b   = (op_reg == atrl_pkg::OP_DROP) ? factor_reg
                                                   : atrl_pkg::FACTOR_W'(w_clamp);

    assign blend_sum  = (PW+1)'(prod_a_reg) + (PW+1)'(prod_b_reg);
    assign avg_blend  = blend_sum[TIME_BITS+7:8];
    assign avg_scaled = (|prod_a_reg[PW-1:TIME_BITS+8]) ? TIME_MAX
                                                        : prod_a_reg[TIME_BITS+7:8];

    assign qsum     = (TIME_BITS+1)'(oldest_reg) + (TIME_BITS+1)'(avg_reg);
    assign min_next = qsum[TIME_BITS] ? TIME_MAX : qsum[TIME_BITS-1:0];

    assign ram_raddr = cmd.scan_issue ? scan_addr_reg : idx;
    assign hit       = cmp_vld_reg && cand_reg && (ram_rdata < oldest_reg);

    atrl_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (ID_COUNT)
    ) u_start_ram (
        .clk   (clk),
        .we    (cmd.do_send && in_range),
        .waddr (idx),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ID_COUNT; i++)
            begin
                valid_reg[i] <= 1'b0;
                used_reg[i]  <= 1'b0;
            end
            avg_reg      <= TIME_BITS'(atrl_pkg::AVG_RESET);
            factor_reg   <= atrl_pkg::SLOWDOWN_RESET;
            weight_reg   <= atrl_pkg::WEIGHT_RESET;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == atrl_pkg::CFG_SLOWDOWN))
            begin
                factor_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == atrl_pkg::CFG_WEIGHT))
            begin
                weight_reg <= cfg_wdata[atrl_pkg::WEIGHT_W-1:0];
            end
            if (cmd.do_send && in_range)
            begin
                valid_reg[idx] <= 1'b1;
                used_reg[idx]  <= 1'b0;
            end
            if (cmd.upd_ack || cmd.upd_drop)
            begin
                valid_reg[idx] <= 1'b0;
                used_reg[idx]  <= 1'b0;
            end
            if (cmd.upd_ack)
            begin
                avg_reg <= avg_blend;
            end
            if (cmd.upd_drop)
            begin
                avg_reg <= avg_scaled;
            end
            if (cmd.mark && found_reg)
            begin
                used_reg[best_reg] <= 1'b1;
            end
            cmp_vld_reg <= cmd.scan_issue;
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= atrl_pkg::op_t'(s_tuser);
            id_reg    <= s_tdata[atrl_pkg::ID_W-1:0];
            now_reg   <= TIME_BITS'(s_tdata[atrl_pkg::S_DATA_W-1:atrl_pkg::ID_W]);
            found_reg <= 1'b0;
            error_reg <= 1'b0;
            min_reg   <= '0;
        end
        if (cmd.set_error)
        begin
            error_reg <= 1'b1;
        end
        if (cmd.latch_elapsed)
        begin
            elapsed_reg <= (now_reg >= ram_rdata) ? (now_reg - ram_rdata) : '0;
        end
        if (cmd.mul)
        begin
            prod_a_reg <= PW'(avg_reg) * PW'(mul_b);
            prod_b_reg <= BW'(elapsed_reg) * BW'(w_new);
        end
        if (cmd.scan_init)
        begin
            scan_addr_reg <= '0;
            oldest_reg    <= now_reg;
            found_reg     <= 1'b0;
        end
        if (cmd.scan_issue)
        begin
            scan_addr_reg <= scan_addr_reg + IW'(1);
            cmp_idx_reg   <= scan_addr_reg;
            cand_reg      <= valid_reg[scan_addr_reg] & ~used_reg[scan_addr_reg];
        end
        if (hit)
        begin
            oldest_reg <= ram_rdata;
            best_reg   <= cmp_idx_reg;
            found_reg  <= 1'b1;
        end
        if (cmd.mark)
        begin
            min_reg <= min_next;
        end
        if (cmd.load_out)
        begin
            m_min_reg   <= atrl_pkg::PORT_TW'(min_reg);
            m_avg_reg   <= atrl_pkg::PORT_TW'(avg_reg);
            m_found_reg <= found_reg;
            m_error_reg <= error_reg;
        end
    end

    assign stat.op        = op_reg;
    assign stat.known     = in_range && valid_reg[idx];
    assign stat.scan_last = (scan_addr_reg == IW'(ID_COUNT - 1));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_avg_reg, m_min_reg};
    assign m_tuser  = {m_error_reg, m_found_reg};

endmodule

/* sv/ack_time_rate_limiter.sv */
// Ack time rate limiter: tracks chunks in flight by id and proposes start times.
// Input stream (s_*): one command per transfer; s_tuser carries the operation
// (send, ack, drop, query), s_tdata the chunk id and the current time.
// Output stream (m_*): exactly one result transfer per command, in order,
// with the proposed minimum start, the average ack time, found and error.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 slowdown factor Q8.8, 1 old-sample weight Q1.8); write only when idle.
// Send, and ack or drop of an unknown id, go straight to the result; drop
// and ack update the average first, and query scans the start-time RAM, one
// entry per cycle through its single read port. The next command is taken in
// the cycle after its result is loaded into the output register, so a result
// may wait on m_tready while a new command runs.
// Reset clears all ids to not in flight and restores the register defaults
// and the initial average of 1 ms; no clearing pass is needed.
// A stalled receiver holds the result; the block stops taking commands once
// a second result is ready and the first is still not taken.
module ack_time_rate_limiter #(
    parameter int ID_COUNT  = 256,
    parameter int TIME_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [atrl_pkg::S_DATA_W-1:0] s_tdata,  // chunk_id[7:0], now_time[55:8]
    input  logic [atrl_pkg::OP_W-1:0]     s_tuser,  // op[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [atrl_pkg::M_DATA_W-1:0] m_tdata,  // min_start[47:0], avg_ack[95:48]
    output logic [atrl_pkg::M_USER_W-1:0] m_tuser,  // found[0], error[1]
    input  logic                          cfg_we,
    input  logic [atrl_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [atrl_pkg::CFG_DW-1:0]   cfg_wdata
);

    atrl_pkg::cmd_t  cmd;
    atrl_pkg::stat_t stat;

    atrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    atrl_dp #(
        .ID_COUNT  (ID_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* sv/atrl_checker.sv */
`include "ack_time_rate_limiter_assert.svh"

module atrl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [atrl_pkg::M_DATA_W-1:0] m_tdata,
    input logic [atrl_pkg::M_USER_W-1:0] m_tuser
);

    `ATRL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `ATRL_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second command taken while one is in progress")

    `ATRL_ASSERT_NOW(a_found_error_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "found and error both set")

    `ATRL_ASSERT_NOW(a_error_no_start, m_tvalid && m_tuser[1], m_tdata[47:0] == 48'd0, "error result with a start time")

    `ATRL_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), !$past(s_tready), "result appeared while idle")

endmodule

bind ack_time_rate_limiter atrl_checker u_atrl_checker (.*);

/* test/atrl_result_checker.sv */
`timescale 1ns / 100ps

module atrl_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [atrl_pkg::S_DATA_W-1:0] s_tdata,   // chunk_id[7:0], now_time[55:8]
    input  logic [atrl_pkg::OP_W-1:0]     s_tuser,   // op[1:0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [atrl_pkg::M_DATA_W-1:0] m_tdata,   // min_start[47:0], avg_ack[95:48]
    input  logic [atrl_pkg::M_USER_W-1:0] m_tuser,   // found[0], error[1]
    input  logic                          cfg_we,
    input  logic [atrl_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [atrl_pkg::CFG_DW-1:0]   cfg_wdata,
    output int                            fail_count,
    output int                            outstanding
);

    localparam int                           SLOTS    = 256;
    localparam logic [atrl_pkg::PORT_TW-1:0] TIME_TOP = '1;

    typedef struct packed {
        logic [atrl_pkg::PORT_TW-1:0] min_start;
        logic [atrl_pkg::PORT_TW-1:0] avg_ack;
        logic                         found;
        logic                         error;
    } ack_report_t;

    logic                          slot_live  [SLOTS];
    logic                          slot_taken [SLOTS];
    logic [atrl_pkg::PORT_TW-1:0]  slot_sent  [SLOTS];
    logic [atrl_pkg::PORT_TW-1:0]  mean_ack;
    logic [atrl_pkg::FACTOR_W-1:0] slowdown;
    logic [atrl_pkg::WEIGHT_W-1:0] weight;
    ack_report_t                   awaited_reports[$];
    ack_report_t                   seen_report;
    ack_report_t                   due_report;
    int                            fails    = 0;
    int                            reported = 0;

    function automatic ack_report_t advance_limiter(atrl_pkg::op_t op,
                                                    logic [atrl_pkg::ID_W-1:0] id,
                                                    logic [atrl_pkg::PORT_TW-1:0] now);
        ack_report_t                  rep;
        logic [63:0]                  wt;
        logic [63:0]                  elapsed;
        logic [63:0]                  acc;
        logic [atrl_pkg::PORT_TW-1:0] oldest;
        logic [atrl_pkg::PORT_TW:0]   total;
        int                           pick;
        rep = '0;
        case (op)
            atrl_pkg::OP_SEND:
            begin
                slot_live[id]  = 1'b1;
                slot_taken[id] = 1'b0;
                slot_sent[id]  = now;
            end
            atrl_pkg::OP_ACK, atrl_pkg::OP_DROP:
            begin
                if (!slot_live[id])
                begin
                    rep.error = 1'b1;
                end
                else if (op == atrl_pkg::OP_ACK)
                begin
                    wt = (weight > atrl_pkg::WEIGHT_ONE) ? 64'(atrl_pkg::WEIGHT_ONE)
                                                         : 64'(weight);
                    elapsed = (now >= slot_sent[id]) ? 64'(now - slot_sent[id]) : 64'd0;
                    acc = wt * 64'(mean_ack) + (64'd256 - wt) * elapsed;
                    mean_ack = acc[55:8];
                    slot_live[id]  = 1'b0;
                    slot_taken[id] = 1'b0;
                end
                else
                begin
                    acc = 64'(mean_ack) * 64'(slowdown);
                    mean_ack = (|acc[63:56]) ? TIME_TOP : acc[55:8];
                    slot_live[id]  = 1'b0;
                    slot_taken[id] = 1'b0;
                end
            end
            default:
            begin
                oldest = now;
                pick   = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && !slot_taken[i] && slot_sent[i] < oldest)
                    begin
                        oldest = slot_sent[i];
                        pick   = i;
                    end
                end
                if (pick >= 0)
                begin
                    slot_taken[pick] = 1'b1;
                    rep.found        = 1'b1;
                end
                total = {1'b0, oldest} + {1'b0, mean_ack};
                rep.min_start = total[atrl_pkg::PORT_TW] ? TIME_TOP
                                                         : total[atrl_pkg::PORT_TW-1:0];
            end
        endcase
        rep.avg_ack = mean_ack;
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_taken[i] = 1'b0;
                slot_sent[i]  = '0;
            end
            mean_ack = atrl_pkg::PORT_TW'(atrl_pkg::AVG_RESET);
            slowdown = atrl_pkg::SLOWDOWN_RESET;
            weight   = atrl_pkg::WEIGHT_RESET;
            awaited_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare before predicting: no result can belong to a same-cycle transfer
            if (m_tvalid && m_tready)
            begin
                seen_report = '{min_start: m_tdata[atrl_pkg::PORT_TW-1:0],
                                avg_ack:   m_tdata[2*atrl_pkg::PORT_TW-1:atrl_pkg::PORT_TW],
                                found:     m_tuser[0],
                                error:     m_tuser[1]};
                if (awaited_reports.size() == 0)
                begin
                    fails++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("%t unexpected result: min_start %h avg %h found %b error %b",
                                 $realtime, seen_report.min_start, seen_report.avg_ack,
                                 seen_report.found, seen_report.error);
                    end
                end
                else
                begin
                    due_report = awaited_reports.pop_front();
                    if (seen_report.min_start !== due_report.min_start ||
                        seen_report.avg_ack   !== due_report.avg_ack   ||
                        seen_report.found     !== due_report.found     ||
                        seen_report.error     !== due_report.error)
                    begin
                        fails++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("%t mismatch: expected min_start %h avg %h found %b error %b",
                                     $realtime, due_report.min_start, due_report.avg_ack,
                                     due_report.found, due_report.error);
                            $display("%t           got min_start %h avg %h found %b error %b",
                                     $realtime, seen_report.min_start, seen_report.avg_ack,
                                     seen_report.found, seen_report.error);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                awaited_reports.push_back(
                    advance_limiter(atrl_pkg::op_t'(s_tuser),
                                    s_tdata[atrl_pkg::ID_W-1:0],
                                    s_tdata[atrl_pkg::ID_W +: atrl_pkg::PORT_TW]));
            end
            if (cfg_we)
            begin
                if (cfg_addr == atrl_pkg::CFG_SLOWDOWN)
                    slowdown = cfg_wdata[atrl_pkg::FACTOR_W-1:0];
                else if (cfg_addr == atrl_pkg::CFG_WEIGHT)
                    weight = cfg_wdata[atrl_pkg::WEIGHT_W-1:0];
            end
            outstanding <= awaited_reports.size();
        end
        fail_count <= fails;
    end

endmodule

/* test/tb_ack_time_rate_limiter.sv */
`timescale 1ns / 100ps

module tb_ack_time_rate_limiter;

    localparam int                           LIMIT_CYCLES = 3_000_000;
    localparam int                           PHASE_ITEMS  = 300;
    localparam logic [atrl_pkg::PORT_TW-1:0] TIME_TOP     = '1;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [atrl_pkg::S_DATA_W-1:0] s_tdata   = '0;   // chunk_id[7:0], now_time[55:8]
    logic [atrl_pkg::OP_W-1:0]     s_tuser   = '0;   // op[1:0]
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [atrl_pkg::M_DATA_W-1:0] m_tdata;          // min_start[47:0], avg_ack[95:48]
    logic [atrl_pkg::M_USER_W-1:0] m_tuser;          // found[0], error[1]
    logic                          cfg_we    = 1'b0;
    logic [atrl_pkg::CFG_AW-1:0]   cfg_addr  = '0;
    logic [atrl_pkg::CFG_DW-1:0]   cfg_wdata = '0;
    logic                          calm      = 1'b0;
    int                            fail_count;
    int                            outstanding;
    logic [atrl_pkg::PORT_TW-1:0]  clock_ns;
    logic [atrl_pkg::ID_W-1:0]     live_ids[$];

    ack_time_rate_limiter #(
        .ID_COUNT  (256),
        .TIME_BITS (48)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    atrl_result_checker u_result_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 29);
    end

    // hold the command until the transfer; valid drops only on an idle cycle
    task automatic push_cmd(atrl_pkg::op_t op, logic [atrl_pkg::ID_W-1:0] id,
                            logic [atrl_pkg::PORT_TW-1:0] now);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_limiter(logic [atrl_pkg::CFG_DW-1:0] factor,
                                   logic [atrl_pkg::CFG_DW-1:0] weight_word);
        cfg_we    <= 1'b1;
        cfg_addr  <= atrl_pkg::CFG_SLOWDOWN;
        cfg_wdata <= factor;
        @(posedge clk);
        cfg_addr  <= atrl_pkg::CFG_WEIGHT;
        cfg_wdata <= weight_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void forget_id(logic [atrl_pkg::ID_W-1:0] id);
        for (int i = live_ids.size() - 1; i >= 0; i--)
        begin
            if (live_ids[i] == id)
                live_ids.delete(i);
        end
    endfunction

    task automatic random_item();
        int                           roll;
        int                           slot;
        atrl_pkg::op_t                op;
        logic [atrl_pkg::ID_W-1:0]    id;
        logic [atrl_pkg::PORT_TW-1:0] now;
        roll     = $urandom_range(0, 99);
        clock_ns = clock_ns + atrl_pkg::PORT_TW'($urandom_range(0, 20000));
        if ($urandom_range(0, 49) == 0)
            clock_ns = clock_ns + {16'h0, 32'($urandom)};
        now = clock_ns;
        id  = atrl_pkg::ID_W'($urandom);
        if (roll < 35)
        begin
            op = atrl_pkg::OP_SEND;
            forget_id(id);
            live_ids.push_back(id);
        end
        else if (roll < 75)
        begin
            op = (roll < 60) ? atrl_pkg::OP_ACK : atrl_pkg::OP_DROP;
            if (live_ids.size() != 0 && $urandom_range(0, 9) < 8)
            begin
                slot = $urandom_range(0, live_ids.size() - 1);
                id   = live_ids[slot];
            end
            forget_id(id);
            // occasionally step back in time, possibly below the send time
            if ($urandom_range(0, 19) == 0)
                now = now - atrl_pkg::PORT_TW'($urandom_range(1, 200000));
        end
        else
        begin
            op = atrl_pkg::OP_QUERY;
        end
        push_cmd(op, id, now);
    endtask

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("[ack_time_rate_limiter] ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   48'd0);
        push_cmd(atrl_pkg::OP_ACK,   8'd0,   48'd10);
        push_cmd(atrl_pkg::OP_DROP,  8'hFF,  48'd20);
        push_cmd(atrl_pkg::OP_SEND,  8'd0,   48'd100);
        push_cmd(atrl_pkg::OP_SEND,  8'hFF,  48'd100);
        push_cmd(atrl_pkg::OP_SEND,  8'd7,   48'd150);
        push_cmd(atrl_pkg::OP_QUERY, 8'hA5,  48'd200);
        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   48'd200);
        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   48'd200);
        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   48'd200);
        push_cmd(atrl_pkg::OP_ACK,   8'd0,   48'd50);
        push_cmd(atrl_pkg::OP_SEND,  8'hFF,  48'd300);
        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   48'd400);
        push_cmd(atrl_pkg::OP_SEND,  8'd9,   48'd1000);
        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   48'd1000);
        push_cmd(atrl_pkg::OP_DROP,  8'hFF,  48'd1200);
        push_cmd(atrl_pkg::OP_ACK,   8'd7,   48'd5000);
        push_cmd(atrl_pkg::OP_SEND,  8'd5,   TIME_TOP);
        push_cmd(atrl_pkg::OP_QUERY, 8'd0,   TIME_TOP);
        push_cmd(atrl_pkg::OP_ACK,   8'd9,   TIME_TOP);
        push_cmd(atrl_pkg::OP_DROP,  8'd5,   TIME_TOP);
        push_cmd(atrl_pkg::OP_ACK,   8'd5,   TIME_TOP);

        for (phase = 0; phase < 6; phase++)
        begin
            s_tvalid <= 1'b0;
            drain_results();
            case (phase)
                1: program_limiter(16'd256, 16'd0);
                2: program_limiter(16'hFFFF, atrl_pkg::CFG_DW'(atrl_pkg::WEIGHT_ONE));
                3: program_limiter(16'($urandom_range(256, 65535)), 16'hFFFF);
                4: program_limiter(16'($urandom_range(256, 65535)),
                                   16'($urandom_range(0, 256)));
                5: program_limiter(16'd257, 16'd255);
                default: ;
            endcase
            calm     <= (phase == 2);
            clock_ns = (phase == 2) ? 48'hFFFF_FF00_0000 : {16'($urandom), 32'($urandom)};
            repeat (PHASE_ITEMS) random_item();
        end

        s_tvalid <= 1'b0;
        drain_results();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("[ack_time_rate_limiter] OK");
        else
            $display("[ack_time_rate_limiter] ERROR");
        $finish;
    end

endmodule
